/* rtl/csrp_pkg.sv */
// Shared types and codes for the byte stack with palindrome check and rotate.
// No dependencies; the datapath, the controller and the top file import this package.
package csrp_pkg;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PAL    = 2'd2,
    OP_ROTATE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_ROT_REJ = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_PAL  = 4'b0100,
    S_ROT  = 4'b1000
  } state_e;

  // Commands from the controller to the datapath, valid for one cycle.
  typedef struct packed {
    logic    push_wr;
    logic    pop_rd;
    logic    pal_init;
    logic    pal_step;
    logic    pal_cmp;
    logic    rot_init;
    logic    rot_rd;
    logic    rot_wr;
    logic    rot_base;
    logic    clr_cnt;
    logic    out_load;
    logic    out_pop;
    logic    out_pal;
    status_e out_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic rot_bad;
    logic walk_nz;
  } sts_t;

endpackage

/* rtl/csrp_in_if.sv */
// Input channel of the byte stack: valid/ready handshake and operation word.
// No dependencies.
interface csrp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] push_byte;
  logic [8:0] rotate_count;

  modport source (output valid, output opcode, output push_byte, output rotate_count,
                  input ready);
  modport sink   (input valid, input opcode, input push_byte, input rotate_count,
                  output ready);
endinterface

/* rtl/csrp_out_if.sv */
// Output channel of the byte stack: valid/ready handshake and result word.
// No dependencies.
interface csrp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] popped_byte;
  logic       palindrome_flag;
  logic [1:0] status;
  logic [8:0] fill_level;
  logic       is_empty;

  modport source (output valid, output popped_byte, output palindrome_flag, output status,
                  output fill_level, output is_empty, input ready);
  modport sink   (input valid, input popped_byte, input palindrome_flag, input status,
                  input fill_level, input is_empty, output ready);
endinterface

/* rtl/csrp_dp.sv */
// Datapath of the byte stack: circular entry memory, base and count, walk pointers,
// compare flag and result register. Depends on csrp_pkg.
module csrp_dp #(
  parameter int DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        push_byte_i,
  input  logic [8:0]        rotate_count_i,
  input  csrp_pkg::cmd_t    cmd_i,
  output csrp_pkg::sts_t    sts_o,
  output logic [7:0]        popped_byte_o,
  output logic              palindrome_flag_o,
  output logic [1:0]        status_o,
  output logic [8:0]        fill_level_o,
  output logic              is_empty_o
);
  import csrp_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = AW + 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > 9) ? CW : 9;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] base_q, base_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] walk_q, walk_d;
  logic [AW-1:0] ptr_a_q, ptr_a_d, ptr_b_q, ptr_b_d;
  logic [CW-1:0] nrot_q;
  logic          shift_q;
  logic          match_q;
  logic [7:0]    rd_a_q, rd_b_q;
  logic [AW-1:0] top_addr, pop_addr;
  logic          wr_en, rd_a_en;
  logic [AW-1:0] wr_addr, rd_a_addr;
  logic [7:0]    wr_data;
  logic          n_is_cnt;

  function automatic logic [AW-1:0] wrap_fn(input logic [SW-1:0] s);
    logic [SW-1:0] t;
    t = (s >= DEPTH_S) ? s - DEPTH_S : s;
    return t[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] inc_fn(input logic [AW-1:0] p);
    return (p == LAST_A) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] dec_fn(input logic [AW-1:0] p);
    return (p == '0) ? LAST_A : p - 1'b1;
  endfunction

  assign top_addr = wrap_fn(SW'(base_q) + SW'(count_q));
  assign pop_addr = wrap_fn(SW'(base_q) + SW'(count_q - 1'b1));
  assign n_is_cnt = MW'(rotate_count_i) == MW'(count_q);

  assign sts_o.full    = count_q == DEPTH_C;
  assign sts_o.empty   = count_q == '0;
  assign sts_o.rot_bad = (count_q == '0) || (rotate_count_i == '0) ||
                         (MW'(rotate_count_i) > MW'(count_q));
  assign sts_o.walk_nz = walk_q != '0;

  // Memory ports
  assign wr_en     = cmd_i.push_wr | cmd_i.rot_wr;
  assign wr_addr   = cmd_i.push_wr ? top_addr : ptr_b_q;
  assign wr_data   = cmd_i.push_wr ? push_byte_i : rd_a_q;
  assign rd_a_en   = cmd_i.pop_rd | cmd_i.pal_step | cmd_i.rot_rd;
  assign rd_a_addr = cmd_i.pop_rd ? pop_addr : ptr_a_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_q <= mem[rd_a_addr];
    end
    if (cmd_i.pal_step) begin
      rd_b_q <= mem[ptr_b_q];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clr_cnt) begin
      count_d = '0;
    end else if (cmd_i.push_wr) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop_rd) begin
      count_d = count_q - 1'b1;
    end

    base_d = base_q;
    if (cmd_i.rot_base && shift_q) begin
      base_d = wrap_fn(SW'(base_q) + SW'(nrot_q));
    end

    walk_d = walk_q;
    if (cmd_i.pal_init) begin
      walk_d = count_q >> 1;
    end else if (cmd_i.rot_init) begin
      walk_d = (sts_o.full || n_is_cnt) ? '0 : CW'(rotate_count_i);
    end else if (cmd_i.pal_step || cmd_i.rot_rd) begin
      walk_d = walk_q - 1'b1;
    end

    ptr_a_d = ptr_a_q;
    ptr_b_d = ptr_b_q;
    if (cmd_i.pal_init) begin
      ptr_a_d = base_q;
      ptr_b_d = pop_addr;
    end else if (cmd_i.rot_init) begin
      ptr_a_d = base_q;
      ptr_b_d = top_addr;
    end else begin
      if (cmd_i.pal_step || cmd_i.rot_rd) begin
        ptr_a_d = inc_fn(ptr_a_q);
      end
      if (cmd_i.pal_step) begin
        ptr_b_d = dec_fn(ptr_b_q);
      end else if (cmd_i.rot_wr) begin
        ptr_b_d = inc_fn(ptr_b_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      base_q  <= '0;
      walk_q  <= '0;
    end else begin
      count_q <= count_d;
      base_q  <= base_d;
      walk_q  <= walk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_a_q <= ptr_a_d;
    ptr_b_q <= ptr_b_d;
    if (cmd_i.rot_init) begin
      nrot_q  <= CW'(rotate_count_i);
      shift_q <= !n_is_cnt;
    end
    if (cmd_i.pal_init) begin
      match_q <= 1'b1;
    end else if (cmd_i.pal_cmp && (rd_a_q != rd_b_q)) begin
      match_q <= 1'b0;
    end
    if (cmd_i.out_load) begin
      popped_byte_o     <= cmd_i.out_pop ? rd_a_q : 8'd0;
      palindrome_flag_o <= cmd_i.out_pal ? match_q : 1'b0;
      status_o          <= cmd_i.out_status;
      fill_level_o      <= 9'(count_d);
      is_empty_o        <= count_d == '0;
    end
  end

endmodule

/* rtl/csrp_ctrl.sv */
// Controller of the byte stack: one-hot state machine, input handshake and
// result valid. Depends on csrp_pkg.
module csrp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     opcode_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  csrp_pkg::sts_t sts_i,
  output csrp_pkg::cmd_t cmd_o
);
  import csrp_pkg::*;

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    pend_d  = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            OP_PUSH: begin
              cmd_o.out_load = 1'b1;
              if (sts_i.full) begin
                cmd_o.out_status = ST_FULL;
              end else begin
                cmd_o.push_wr = 1'b1;
              end
            end
            OP_POP: begin
              if (sts_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_EMPTY;
              end else begin
                cmd_o.pop_rd = 1'b1;
                state_d      = S_POP;
              end
            end
            OP_PAL: begin
              cmd_o.pal_init = 1'b1;
              state_d        = S_PAL;
            end
            OP_ROTATE: begin
              if (sts_i.rot_bad) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_ROT_REJ;
              end else begin
                cmd_o.rot_init = 1'b1;
                state_d        = S_ROT;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_pop  = 1'b1;
        state_d        = S_IDLE;
      end
      S_PAL: begin
        // Read one mirrored pair per cycle, compare it the cycle after.
        cmd_o.pal_step = sts_i.walk_nz;
        cmd_o.pal_cmp  = pend_q;
        pend_d         = sts_i.walk_nz;
        if (!sts_i.walk_nz && !pend_q) begin
          cmd_o.clr_cnt  = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.out_pal  = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_ROT: begin
        // Copy bottom entries above the top, one per cycle, then move the base unless n is the level.
        cmd_o.rot_rd = sts_i.walk_nz;
        cmd_o.rot_wr = pend_q;
        pend_d       = sts_i.walk_nz;
        if (!sts_i.walk_nz && !pend_q) begin
          cmd_o.rot_base = 1'b1;
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/char_stack_rotate_palindrome.sv */
// Results: push, full push, empty pop and rejected rotate give their word in the cycle
//   after acceptance; pop loads its word from the pop state; palindrome check reads and
//   compares mirrored pairs in the check state; rotate copies entries, then moves the base.
// Throughput: one item in flight; pushes every cycle while out ready is high. The single
//   write port of the entry memory sets the rotate copy rate at one entry per cycle.
// Reset: asynchronous, active low; empties the stack, the entry memory is not cleared.
module char_stack_rotate_palindrome #(
  parameter int STACK_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  csrp_in_if.sink           in_i,
  csrp_out_if.source        out_o
);
  import csrp_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic accept;

  // The controller sequences each operation; the datapath owns the entries.
  csrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .opcode_i    (in_i.opcode),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Entries sit in a circular buffer; rotate moves the base instead of every word.
  csrp_dp #(
    .DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_byte_i       (in_i.push_byte),
    .rotate_count_i    (in_i.rotate_count),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .popped_byte_o     (out_o.popped_byte),
    .palindrome_flag_o (out_o.palindrome_flag),
    .status_o          (out_o.status),
    .fill_level_o      (out_o.fill_level),
    .is_empty_o        (out_o.is_empty)
  );

  assign accept = in_i.valid && in_i.ready;

`ifndef ASSERT_OFF
  // Never overwrite a result word that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_o.valid || out_o.ready))
    else $error("result word overwritten before delivery");

  // Never write a push into a full stack.
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push_wr |-> !sts.full)
    else $error("push written into full stack");

  // A pop from a non-empty stack loads its word into the result register in the cycle after acceptance.
  a_pop_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.opcode == OP_POP) && !sts.empty) |=> cmd.out_load && cmd.out_pop)
    else $error("pop result late");
`endif

endmodule
